// ----- rtl/lpht_pkg.sv -----
`default_nettype none

package lpht_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned DEST_W  = 32;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_PRESENT  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_HIT      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                     valid;
    logic [KEY_W-1:0]         key;
    logic signed [DEST_W-1:0] dest;
    logic [VALUE_W-1:0]       value;
  } slot_t;

endpackage

`default_nettype wire

// ----- rtl/lpht_req_if.sv -----
`default_nettype none

interface lpht_req_if;
  import lpht_pkg::*;

  logic                     valid;
  logic                     ready;
  req_e                     req_type;
  logic [KEY_W-1:0]         key;
  logic signed [DEST_W-1:0] dest;
  logic [VALUE_W-1:0]       value;

  modport source (
    output valid, req_type, key, dest, value,
    input  ready
  );

  modport sink (
    input  valid, req_type, key, dest, value,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/lpht_rsp_if.sv -----
`default_nettype none

interface lpht_rsp_if;
  import lpht_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic               found;
  logic [VALUE_W-1:0] value_out;

  modport source (
    output valid, status, found, value_out,
    input  ready
  );

  modport sink (
    input  valid, status, found, value_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/linear_probe_hash_table.sv -----
`default_nettype none

// Open-addressing hash table on (key, dest) pairs with linear probing from
// slot key mod TABLE_DEPTH. After reset the block first clears the table,
// one slot per cycle, and accepts no request during that pass. A request
// steps through ST_READ and ST_CHECK once per probed slot: ST_READ reads
// the single-port slot memory and ST_CHECK compares the registered read
// data. A request is accepted only while the sequencer is idle, but a
// finished result may wait in the output register while the next request
// is taken. Every request produces exactly one response transaction.
module linear_probe_hash_table (
  input  wire          clk_i,
  input  wire          rst_ni,
  lpht_req_if.sink     req_i,
  lpht_rsp_if.source   rsp_o
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  req_e                     req_type_q;
  logic [KEY_W-1:0]         key_q;
  logic signed [DEST_W-1:0] dest_q;
  logic [VALUE_W-1:0]       value_q;

  status_e            res_status_q, res_status_d;
  logic               res_found_q, res_found_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;

  logic               rsp_valid_q, rsp_valid_d;
  status_e            rsp_status_q;
  logic               rsp_found_q;
  logic [VALUE_W-1:0] rsp_value_q;

  slot_t mem [TABLE_DEPTH];
  slot_t rdata_q;
  slot_t wdata;
  logic  mem_we;

  logic req_acc;
  logic out_free;
  logic slot_match;
  logic last_probe;
  logic [IDX_W-1:0] home_idx;
  logic [IDX_W-1:0] next_idx;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign home_idx   = IDX_W'(req_i.key % TABLE_DEPTH);
  assign next_idx   = (idx_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign slot_match = rdata_q.valid && (rdata_q.key == key_q) && (rdata_q.dest == dest_q);
  assign last_probe = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == IDX_W'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!rdata_q.valid || slot_match || last_probe) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    wdata        = '0;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = next_idx;
      end
      ST_IDLE: begin
        if (req_acc) begin
          idx_d = home_idx;
          cnt_d = '0;
        end
      end
      ST_CHECK: begin
        res_found_d = 1'b0;
        res_value_d = '0;
        if (!rdata_q.valid) begin
          // Empty slot ends the chain: insert here, or report a miss.
          res_status_d = STATUS_INSERTED;
          if (req_type_q == REQ_INSERT) begin
            mem_we = 1'b1;
            wdata  = '{valid: 1'b1, key: key_q, dest: dest_q, value: value_q};
          end
        end else if (slot_match) begin
          if (req_type_q == REQ_INSERT) begin
            res_status_d = STATUS_PRESENT;
          end else begin
            res_status_d = STATUS_HIT;
            res_found_d  = 1'b1;
            res_value_d  = rdata_q.value;
          end
        end else if (last_probe) begin
          res_status_d = (req_type_q == REQ_INSERT) ? STATUS_FULL : STATUS_INSERTED;
        end else begin
          idx_d = next_idx;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) rsp_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q <= req_i.req_type;
      key_q      <= req_i.key;
      dest_q     <= req_i.dest;
      value_q    <= req_i.value;
    end
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    if (state_q == ST_RESP && out_free) begin
      rsp_status_q <= res_status_q;
      rsp_found_q  <= res_found_q;
      rsp_value_q  <= res_value_q;
    end
  end

  // Slot memory: one write port and one registered read port, both at idx_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_q] <= wdata;
    rdata_q <= mem[idx_q];
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.value_out = rsp_value_q;

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !rsp_valid_q)
    else $error("response valid during table clear");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
    else $error("slot memory written outside clear or check");

  a_found_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_found_q == (rsp_status_q == STATUS_HIT)))
    else $error("found flag disagrees with status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_found_q) |-> (rsp_value_q == '0))
    else $error("nonzero value without a hit");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == ST_READ && cnt_q == '0))
    else $error("accepted request did not start a probe");

endmodule

`default_nettype wire
